FILE: hdl/b128_pkg.sv
// b128_pkg: shared types and constants for the binary128 add/sub unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package b128_pkg;
    localparam logic [14:0] EXP_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_DOWN    = 2'd1,
        RM_UP      = 2'd2,
        RM_ZERO    = 2'd3
    } rmode_t;

    // aligned operands handed from the front end to the back end
    typedef struct packed {
        logic         special;   // result fully decided in front end
        logic [127:0] spec_res;
        logic         spec_inv;
        logic         sign;
        logic         eff_sub;
        logic [14:0]  e;
        logic [115:0] a;
        logic [115:0] b;
        logic [1:0]   rm;
    } b128_mid_t;

    typedef struct packed {
        logic [127:0] res;
        logic         inv;
        logic         inx;
        logic         ovf;
    } b128_res_t;
endpackage
`default_nettype wire

FILE: hdl/b128_if.sv
// b128_if: valid/ready channel interfaces for operands, results and config
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface b128_op_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] x_hi;
    logic [63:0] x_lo;
    logic [63:0] y_hi;
    logic [63:0] y_lo;
    modport source (output valid, operation, x_hi, x_lo, y_hi, y_lo, input ready);
    modport sink (input valid, operation, x_hi, x_lo, y_hi, y_lo, output ready);
endinterface

interface b128_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_hi;
    logic [63:0] res_lo;
    logic        flag_invalid;
    logic        flag_inexact;
    logic        flag_overflow;
    modport source (output valid, res_hi, res_lo, flag_invalid, flag_inexact,
                    flag_overflow, input ready);
    modport sink (input valid, res_hi, res_lo, flag_invalid, flag_inexact,
                  flag_overflow, output ready);
endinterface

interface b128_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/b128_align.sv
// b128_align: operand swap, special cases and significand alignment
// depends on b128_pkg
`timescale 1ns / 1ps
`default_nettype none
module b128_align (
    input  wire logic [1:0]   rm,
    input  wire logic         operation,
    input  wire logic [127:0] x,
    input  wire logic [127:0] y,
    output b128_pkg::b128_mid_t mid
);
    logic [127:0] yy, big, sml;
    logic         swap, big_nan, sml_nan, sml_snan, opp;
    logic [14:0]  ea, eb, ea1, eb1, dif;
    logic [115:0] sa, sb;
    logic [115:0] lost_mask;

    always_comb
    begin
        yy   = {y[127] ^ operation, y[126:0]};
        swap = x[126:0] < yy[126:0];
        big  = swap ? yy : x;
        sml  = swap ? x : yy;
        ea   = big[126:112];
        eb   = sml[126:112];
        opp  = big[127] ^ sml[127];
        big_nan  = (ea == b128_pkg::EXP_MAX) && (big[111:0] != '0);
        sml_nan  = (eb == b128_pkg::EXP_MAX) && (sml[111:0] != '0);
        sml_snan = sml_nan && !sml[111];

        mid = '0;
        mid.rm      = rm;
        mid.sign    = big[127];
        mid.eff_sub = opp;
        if (big_nan) begin
            mid.special  = 1'b1;
            mid.spec_res = big | {16'h0000, 1'b1, 111'd0};
            mid.spec_inv = !big[111] || sml_snan;
        end else if (ea == b128_pkg::EXP_MAX) begin
            mid.special = 1'b1;
            if (eb == b128_pkg::EXP_MAX && opp) begin
                mid.spec_res = {1'b0, b128_pkg::EXP_MAX, 1'b1, 111'd0};
                mid.spec_inv = 1'b1;
            end else begin
                mid.spec_res = big;
            end
        end else if (big[126:0] == '0) begin
            mid.special  = 1'b1;
            mid.spec_res = {opp ? (rm == b128_pkg::RM_DOWN) : big[127], 127'd0};
        end

        ea1 = (ea == '0) ? 15'd1 : ea;
        eb1 = (eb == '0) ? 15'd1 : eb;
        dif = ea1 - eb1;
        sa  = {(ea != '0), big[111:0], 3'b000};
        sb  = {(eb != '0), sml[111:0], 3'b000};
        mid.e = ea1;
        mid.a = sa;
        lost_mask = '0;
        if (dif >= 15'd116) begin
            mid.b = {115'd0, (sb != '0)};
        end else begin
            lost_mask = ~({116{1'b1}} << dif[6:0]);
            mid.b = (sb >> dif[6:0]) | {115'd0, ((sb & lost_mask) != '0)};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/b128_round.sv
// b128_round: significand add, normalize, round and pack
// depends on b128_pkg
`timescale 1ns / 1ps
`default_nettype none
module b128_round (
    input  wire b128_pkg::b128_mid_t mid,
    output b128_pkg::b128_res_t res
);
    logic [116:0] s, n;
    logic [6:0]   m, sh;
    logic [15:0]  e;
    logic [2:0]   rb;
    logic [113:0] q;
    logic         inc, to_inf, found;

    always_comb
    begin
        s = mid.eff_sub ? ({1'b0, mid.a} - {1'b0, mid.b})
                        : ({1'b0, mid.a} + {1'b0, mid.b});
        m = '0;
        found = 1'b0;
        for (int i = 116; i >= 0; i--) begin
            if (!found && s[i]) begin
                m = 7'(i);
                found = 1'b1;
            end
        end
        e = {1'b0, mid.e};
        n = s;
        sh = '0;
        if (m > 7'd115) begin
            n = {1'b0, s[116:2], s[1] | s[0]};
            e = e + 16'd1;
        end else if (m < 7'd115) begin
            sh = 7'd115 - m;
            if ({9'd0, sh} > e - 16'd1) sh = 7'(e - 16'd1);
            n = s << sh;
            e = e - {9'd0, sh};
        end
        rb = n[2:0];
        q  = {1'b0, n[115:3]};
        case (mid.rm)
            b128_pkg::RM_NEAREST: inc = rb > 3'd4 || (rb == 3'd4 && q[0]);
            b128_pkg::RM_DOWN:    inc = rb != '0 && mid.sign;
            b128_pkg::RM_UP:      inc = rb != '0 && !mid.sign;
            default:              inc = 1'b0;
        endcase
        if (inc) begin
            q = q + 114'd1;
            if (q[113]) begin
                q = q >> 1;
                e = e + 16'd1;
            end
        end
        to_inf = mid.rm == b128_pkg::RM_NEAREST || (mid.rm == b128_pkg::RM_DOWN && mid.sign)
                 || (mid.rm == b128_pkg::RM_UP && !mid.sign);

        res = '0;
        if (mid.special) begin
            res.res = mid.spec_res;
            res.inv = mid.spec_inv;
        end else if (s == '0) begin
            res.res = {(mid.rm == b128_pkg::RM_DOWN), 127'd0};
        end else if (e >= {1'b0, b128_pkg::EXP_MAX}) begin
            res.inx = 1'b1;
            res.ovf = 1'b1;
            res.res = to_inf ? {mid.sign, b128_pkg::EXP_MAX, 112'd0}
                             : {mid.sign, b128_pkg::EXP_MAX - 15'd1, {112{1'b1}}};
        end else begin
            res.inx = rb != '0;
            res.res = {mid.sign, q[112] ? e[14:0] : 15'd0, q[111:0]};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/binary128_add_sub_unit.sv
// binary128_add_sub_unit: IEEE binary128 adder/subtracter top level
// depends on b128_pkg, b128_if, b128_align, b128_round
// operand word -> input register -> result register, whose valid drives res.valid
// throughput: one word per cycle unless res.ready stalls; input register,
//   then one pass of align/add/normalize/round into the result register
// reset: rst_n async active low clears valids and rounding mode (nearest-even)
`timescale 1ns / 1ps
`default_nettype none
module binary128_add_sub_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    b128_cfg_if.sink  cfg,
    b128_op_if.sink   op,
    b128_res_if.source res
);
    logic [1:0]   rm_reg;
    logic         in_vld_reg, out_vld_reg;
    logic         in_op_reg;
    logic [127:0] in_x_reg, in_y_reg;
    b128_pkg::b128_mid_t mid;
    b128_pkg::b128_res_t rr, out_reg;
    logic         adv;

    // result register drains or is empty -> stage 1 can move
    assign adv       = !out_vld_reg || res.ready;
    assign op.ready  = !in_vld_reg || adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rm_reg      <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg.valid) rm_reg <= cfg.data;
            if (op.ready) in_vld_reg <= op.valid;
            if (adv) out_vld_reg <= in_vld_reg;
        end
    end

    // operand and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (op.ready && op.valid) begin
            in_op_reg <= op.operation;
            in_x_reg  <= {op.x_hi, op.x_lo};
            in_y_reg  <= {op.y_hi, op.y_lo};
        end
        if (adv && in_vld_reg) out_reg <= rr;
    end

    b128_align u_align (
        .rm        (rm_reg),
        .operation (in_op_reg),
        .x         (in_x_reg),
        .y         (in_y_reg),
        .mid       (mid)
    );

    b128_round u_round (
        .mid (mid),
        .res (rr)
    );

    assign res.valid         = out_vld_reg;
    assign res.res_hi        = out_reg.res[127:64];
    assign res.res_lo        = out_reg.res[63:0];
    assign res.flag_invalid  = out_reg.inv;
    assign res.flag_inexact  = out_reg.inx;
    assign res.flag_overflow = out_reg.ovf;
endmodule
`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking testbench for binary128_add_sub_unit
// depends on b128_pkg, b128_if and the unit's rtl
`timescale 1ns / 1ps
`default_nettype none
module tb;
    typedef struct {
        logic        operation;
        logic [63:0] x_hi;
        logic [63:0] x_lo;
        logic [63:0] y_hi;
        logic [63:0] y_lo;
    } op_word_t;

    typedef struct {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
        logic        inv;
        logic        inx;
        logic        ovf;
    } sum_word_t;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    b128_cfg_if cfg ();
    b128_op_if  op ();
    b128_res_if res ();

    binary128_add_sub_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .op    (op.sink),
        .res   (res.source)
    );

    always #4 clk = ~clk;

    op_word_t  pending_ops[$];
    sum_word_t expected_sums[$];
    b128_pkg::rmode_t round_mode = b128_pkg::RM_NEAREST;
    int        errors = 0;
    int        cycles = 0;
    int        op_gap = 0;
    int        res_gap = 0;
    logic      cfg_req = 1'b0;
    logic [1:0] cfg_val = 2'd0;
    logic      cfg_done = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int top_bit(logic [127:0] v);
        for (int i = 127; i >= 0; i--)
            if (v[i]) return i;
        return 0;
    endfunction

    function automatic logic [127:0] shr_sticky(logic [127:0] v, int n);
        logic [127:0] mask;
        if (n == 0) return v;
        if (n >= 128) return {127'd0, |v};
        mask = (128'd1 << n) - 1;
        return (v >> n) | {127'd0, |(v & mask)};
    endfunction

    // bit-exact sum of two binary128 operands under the current rounding mode
    function automatic sum_word_t binary128_sum(op_word_t w, b128_pkg::rmode_t rm);
        logic [127:0] big, lil, a, b, s;
        logic [63:0]  ah, bh;
        logic         sign, b_snan, inc;
        int           ea, eb, e, m, sh;
        logic [2:0]   rb;
        sum_word_t    o;
        big = {w.x_hi, w.x_lo};
        lil = {w.y_hi ^ {w.operation, 63'd0}, w.y_lo};
        if (lil[126:0] > big[126:0])
        begin
            s = big; big = lil; lil = s;
        end
        ah = big[127:64];
        bh = lil[127:64];
        sign = ah[63];
        ea = ah[62:48];
        eb = bh[62:48];
        o = '{0, 0, 0, 0, 0};
        if (ea == b128_pkg::EXP_MAX)
        begin
            if (big[111:0] != 0)
            begin
                // nan propagation: quiet the larger operand, keep its sign
                b_snan = eb == b128_pkg::EXP_MAX && lil[111:0] != 0 && !bh[47];
                o.res_hi = ah | (64'd1 << 47);
                o.res_lo = big[63:0];
                o.inv = !ah[47] || b_snan;
                return o;
            end
            if (eb == b128_pkg::EXP_MAX && ah[63] != bh[63])
            begin
                o.res_hi = {1'b0, b128_pkg::EXP_MAX, 1'b1, 47'd0};
                o.inv = 1'b1;
                return o;
            end
            o.res_hi = ah;
            o.res_lo = big[63:0];
            return o;
        end
        if (big[126:0] == 0)
        begin
            if (ah[63] != bh[63]) sign = (rm == b128_pkg::RM_DOWN);
            o.res_hi = {sign, 63'd0};
            return o;
        end
        a = {15'd0, ea != 0, big[111:0]} << 3;
        b = {15'd0, eb != 0, lil[111:0]} << 3;
        e = (ea != 0) ? ea : 1;
        if (eb == 0) eb = 1;
        b = shr_sticky(b, e - eb);
        s = (ah[63] != bh[63]) ? a - b : a + b;
        if (s == 0)
        begin
            o.res_hi = {rm == b128_pkg::RM_DOWN, 63'd0};
            return o;
        end
        m = top_bit(s);
        if (m > 115)
        begin
            s = shr_sticky(s, 1);
            e++;
        end
        else if (m < 115)
        begin
            sh = 115 - m;
            if (sh > e - 1) sh = e - 1;
            s = s << sh;
            e -= sh;
        end
        rb = s[2:0];
        s = s >> 3;
        case (rm)
            b128_pkg::RM_NEAREST: inc = rb > 4 || (rb == 4 && s[0]);
            b128_pkg::RM_DOWN:    inc = rb != 0 && sign;
            b128_pkg::RM_UP:      inc = rb != 0 && !sign;
            default:              inc = 1'b0;
        endcase
        if (inc)
        begin
            s = s + 1;
            if (s[113])
            begin
                s = s >> 1;
                e++;
            end
        end
        if (e >= b128_pkg::EXP_MAX)
        begin
            o.inx = 1'b1;
            o.ovf = 1'b1;
            if (rm == b128_pkg::RM_NEAREST || (rm == b128_pkg::RM_DOWN && sign) ||
                (rm == b128_pkg::RM_UP && !sign))
                o.res_hi = {sign, b128_pkg::EXP_MAX, 48'd0};
            else
            begin
                o.res_hi = {sign, b128_pkg::EXP_MAX - 15'd1, {48{1'b1}}};
                o.res_lo = '1;
            end
            return o;
        end
        o.res_hi = {sign, s[112] ? e[14:0] : 15'd0, s[111:64]};
        o.res_lo = s[63:0];
        o.inx = rb != 0;
        return o;
    endfunction

    // operand driver: pops pending words, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op.valid <= 1'b0;
            op.operation <= 1'b0;
            op.x_hi <= '0;
            op.x_lo <= '0;
            op.y_hi <= '0;
            op.y_lo <= '0;
            op_gap <= 0;
        end
        else
        begin
            if (op.valid && op.ready)
            begin
                expected_sums.push_back(binary128_sum('{op.operation, op.x_hi, op.x_lo,
                                                       op.y_hi, op.y_lo}, round_mode));
            end
            if (!op.valid || op.ready)
            begin
                if (op_gap > 0 || pending_ops.size() == 0)
                begin
                    op.valid <= 1'b0;
                    if (op_gap > 0) op_gap <= op_gap - 1;
                end
                else
                begin
                    op_word_t w;
                    w = pending_ops.pop_front();
                    op.valid <= 1'b1;
                    op.operation <= w.operation;
                    op.x_hi <= w.x_hi;
                    op.x_lo <= w.x_lo;
                    op.y_hi <= w.y_hi;
                    op.y_lo <= w.y_lo;
                    op_gap <= pick_gap();
                end
            end
        end
    end

    // config driver: one write per request, only while idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.data <= 2'd0;
            cfg_done <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            cfg.valid <= 1'b0;
            round_mode <= b128_pkg::rmode_t'(cfg.data);
            cfg_done <= 1'b1;
        end
        else if (cfg_req && !cfg.valid && !cfg_done)
        begin
            cfg.valid <= 1'b1;
            cfg.data <= cfg_val;
        end
        else if (!cfg_req)
            cfg_done <= 1'b0;
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_gap <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result word %h_%h", $time,
                             res.res_hi, res.res_lo);
                end
                else
                begin
                    sum_word_t x;
                    logic bad;
                    x = expected_sums.pop_front();
                    bad = 1'b0;
                    if (x.res_hi !== res.res_hi || x.res_lo !== res.res_lo)
                    begin
                        bad = 1'b1;
                        $display("%0t: result expected %h_%h actual %h_%h", $time,
                                 x.res_hi, x.res_lo, res.res_hi, res.res_lo);
                    end
                    if (x.inv !== res.flag_invalid || x.inx !== res.flag_inexact ||
                        x.ovf !== res.flag_overflow)
                    begin
                        bad = 1'b1;
                        $display("%0t: flags inv/inx/ovf expected %b%b%b actual %b%b%b",
                                 $time, x.inv, x.inx, x.ovf, res.flag_invalid,
                                 res.flag_inexact, res.flag_overflow);
                    end
                    if (bad) errors <= errors + 1;
                end
            end
            if (res_gap > 0)
            begin
                res.ready <= 1'b0;
                res_gap <= res_gap - 1;
            end
            else
            begin
                res.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) res_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random operand biased toward interesting exponents
    function automatic logic [127:0] pick_operand(logic [127:0] other);
        logic [127:0] v;
        int k;
        v = {rand64(), rand64()};
        k = $urandom_range(0, 99);
        if (k < 8) v[126:112] = 15'd0;
        else if (k < 14) v[126:112] = b128_pkg::EXP_MAX;
        else if (k < 20) v[126:112] = b128_pkg::EXP_MAX - 15'($urandom_range(1, 3));
        else if (k < 26) v[111:0] = '0;
        else if (k < 60) v[126:112] = other[126:112] + 15'($urandom_range(0, 8)) - 15'd4;
        else if (k < 70) v[126:112] = other[126:112] + 15'($urandom_range(0, 240)) - 15'd120;
        else if (k < 76)
        begin
            // near-cancellation: same magnitude, low bits perturbed
            v = other;
            v[7:0] = 8'($urandom());
        end
        return v;
    endfunction

    task automatic push_op(logic opn, logic [127:0] x, logic [127:0] y);
        pending_ops.push_back('{opn, x[127:64], x[63:0], y[127:64], y[63:0]});
    endtask

    task automatic drain_and_set(b128_pkg::rmode_t rm);
        while (pending_ops.size() != 0 || op.valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_val = rm;
        cfg_req = 1'b1;
        while (!cfg_done) @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [127:0] x, y;
        localparam logic [127:0] QNAN = {1'b0, b128_pkg::EXP_MAX, 1'b1, 111'd0};
        localparam logic [127:0] SNAN = {1'b0, b128_pkg::EXP_MAX, 1'b0, 110'd0, 1'b1};
        localparam logic [127:0] INF = {1'b0, b128_pkg::EXP_MAX, 112'd0};
        localparam logic [127:0] MAXN = {1'b0, b128_pkg::EXP_MAX - 15'd1, {112{1'b1}}};
        localparam logic [127:0] ONE = {1'b0, 15'h3FFF, 112'd0};
        localparam logic [127:0] MINSUB = 128'd1;
        localparam logic [127:0] NEG = {1'b1, 127'd0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 6; ph++)
        begin
            b128_pkg::rmode_t rm;
            rm = b128_pkg::rmode_t'((ph < 4) ? ph : $urandom_range(0, 3));
            drain_and_set(rm);
            if (ph < 4)
            begin
                // directed: nans, infinities, zeros, overflow, subnormals, ties
                push_op(1'b0, QNAN, ONE);
                push_op(1'b0, ONE, SNAN | NEG);
                push_op(1'b1, SNAN, QNAN);
                push_op(1'b1, INF, INF);
                push_op(1'b0, INF, INF | NEG);
                push_op(1'b0, INF | NEG, ONE);
                push_op(1'b0, 128'd0, NEG);
                push_op(1'b1, 128'd0, 128'd0);
                push_op(1'b0, NEG, NEG);
                push_op(1'b1, ONE, ONE);
                push_op(1'b0, MAXN, MAXN);
                push_op(1'b1, MAXN | NEG, MAXN);
                push_op(1'b0, MAXN, {1'b0, 15'h3F8E, 112'd0});
                push_op(1'b0, MINSUB, MINSUB);
                push_op(1'b1, MINSUB, {1'b0, 15'd1, 112'd0});
                push_op(1'b0, ONE, 128'd1);
                push_op(1'b0, ONE, {1'b0, 15'h3F8E, 112'd0});
                push_op(1'b0, ONE | NEG, {1'b0, 15'h3F8E, 112'd3});
                push_op(1'b1, '1, '1);
                push_op(1'b0, {1'b0, 15'h3FFF, {112{1'b1}}}, {1'b0, 15'h3F8F, 112'd0});
            end
            for (int i = 0; i < 100; i++)
            begin
                x = pick_operand({rand64(), rand64()});
                y = pick_operand(x);
                if ($urandom_range(0, 1)) push_op(1'($urandom()), y, x);
                else push_op(1'($urandom()), x, y);
            end
        end
        while (pending_ops.size() != 0 || op.valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
